FILE: design/vrba_pkg.sv
// shared widths, types and constants of the vector rotation pipeline
package vrba_pkg;

    localparam int ITERATIONS = 16;
    localparam int TABLE_LEN  = 24;
    localparam int N_STAGES   = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;

    localparam int IN_W   = 16;
    localparam int OUT_W  = 17;
    localparam int FRAC_W = 16;
    localparam int XY_W   = 36;
    localparam int Z_W    = 32;

    localparam int GAIN_W = 31;
    localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 31'sd652032874;
    localparam int RND_SH = 46;

    // latency in cycles from an accepted start to the result strobe
    localparam int LATENCY = N_STAGES + 3;

    localparam logic signed [Z_W-1:0] ATAN_TAB [TABLE_LEN] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cordic;

endpackage

FILE: design/vrba_quad.sv
// quadrant reduction stage: exact quarter-turn swap and residual angle
module vrba_quad
    import vrba_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic signed [IN_W-1:0] i_vec_x,
    input  logic signed [IN_W-1:0] i_vec_y,
    input  logic        [IN_W-1:0] i_rot_angle,
    output logic                   o_valid,
    output t_cordic                o_data
);

    logic        [IN_W-1:0] angle_bias;
    logic        [1:0]      quad;
    logic signed [IN_W-1:0] resid;
    logic signed [IN_W:0]   x_ext, y_ext, x_int, y_int;
    t_cordic                n_data;
    t_cordic                r_data;
    logic                   r_valid;

    assign angle_bias = i_rot_angle + 16'h2000;
    assign quad       = angle_bias[IN_W-1:IN_W-2];
    assign resid      = signed'({i_rot_angle[IN_W-1:IN_W-2] - quad, i_rot_angle[IN_W-3:0]});
    assign x_ext      = (IN_W+1)'(i_vec_x);
    assign y_ext      = (IN_W+1)'(i_vec_y);

    always_comb begin
        case (quad)
            2'd1: begin
                x_int = -y_ext;
                y_int = x_ext;
            end
            2'd2: begin
                x_int = -x_ext;
                y_int = -y_ext;
            end
            2'd3: begin
                x_int = y_ext;
                y_int = -x_ext;
            end
            default: begin
                x_int = x_ext;
                y_int = y_ext;
            end
        endcase
        n_data.x = XY_W'(x_int) <<< FRAC_W;
        n_data.y = XY_W'(y_int) <<< FRAC_W;
        n_data.z = Z_W'(resid) <<< 16;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: design/vrba_cordic.sv
// rotation-mode cordic, one registered stage per iteration
module vrba_cordic
    import vrba_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_cordic i_data,
    output logic    o_valid,
    output t_cordic o_data
);

    t_cordic r_data [N_STAGES];
    logic    r_vld  [N_STAGES];

    for (genvar k = 0; k < N_STAGES; k++) begin : g_stage
        t_cordic                src;
        logic                   src_vld;
        logic signed [XY_W-1:0] dx, dy;
        t_cordic                n_data;

        if (k == 0) begin : g_first
            assign src     = i_data;
            assign src_vld = i_valid;
        end else begin : g_next
            assign src     = r_data[k-1];
            assign src_vld = r_vld[k-1];
        end

        // arithmetic shifts floor, as the iteration needs
        assign dx = src.y >>> k;
        assign dy = src.x >>> k;

        always_comb begin
            if (!src.z[Z_W-1]) begin
                n_data.x = src.x - dx;
                n_data.y = src.y + dy;
                n_data.z = src.z - ATAN_TAB[k];
            end else begin
                n_data.x = src.x + dx;
                n_data.y = src.y - dy;
                n_data.z = src.z + ATAN_TAB[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_data[k] <= n_data;
        end
    end

    assign o_valid = r_vld[N_STAGES-1];
    assign o_data  = r_data[N_STAGES-1];

endmodule

FILE: design/vrba_gain.sv
// gain compensation: split multiply by the inverse cordic gain, then round to integer
module vrba_gain
    import vrba_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [XY_W-1:0]  i_x,
    input  logic signed [XY_W-1:0]  i_y,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_x,
    output logic signed [OUT_W-1:0] o_y
);

    localparam int HI_W  = XY_W - FRAC_W;
    localparam int PH_W  = HI_W + GAIN_W;
    localparam int PL_W  = FRAC_W + 1 + GAIN_W;
    localparam int SUM_W = PH_W + FRAC_W + 1;

    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (RND_SH - 1);

    logic signed [HI_W-1:0]   xh, yh;
    logic signed [FRAC_W:0]   xl, yl;
    logic signed [PH_W-1:0]   r_xh_p, r_yh_p;
    logic signed [PL_W-1:0]   r_xl_p, r_yl_p;
    logic signed [SUM_W-1:0]  n_xs, n_ys;
    logic signed [OUT_W-1:0]  r_x, r_y;
    logic                     r_vld_a, r_vld_b;

    // high part signed, low part as a non-negative 17-bit value
    assign xh = i_x[XY_W-1:FRAC_W];
    assign yh = i_y[XY_W-1:FRAC_W];
    assign xl = signed'({1'b0, i_x[FRAC_W-1:0]});
    assign yl = signed'({1'b0, i_y[FRAC_W-1:0]});

    always_ff @(posedge i_clk) begin
        r_xh_p <= PH_W'(xh) * PH_W'(GAIN_Q30);
        r_yh_p <= PH_W'(yh) * PH_W'(GAIN_Q30);
        r_xl_p <= PL_W'(xl) * PL_W'(GAIN_Q30);
        r_yl_p <= PL_W'(yl) * PL_W'(GAIN_Q30);
    end

    assign n_xs = (SUM_W'(r_xh_p) <<< FRAC_W) + SUM_W'(r_xl_p) + RND_HALF;
    assign n_ys = (SUM_W'(r_yh_p) <<< FRAC_W) + SUM_W'(r_yl_p) + RND_HALF;

    always_ff @(posedge i_clk) begin
        r_x <= n_xs[RND_SH+OUT_W-1:RND_SH];
        r_y <= n_ys[RND_SH+OUT_W-1:RND_SH];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            r_vld_a <= i_valid;
            r_vld_b <= r_vld_a;
        end
    end

    assign o_valid = r_vld_b;
    assign o_x     = r_x;
    assign o_y     = r_y;

endmodule

FILE: design/vector_rotate_by_angle.sv
// top level of the pipelined vector rotation block
//
// usage
//   - raise start with i_vec_x, i_vec_y and i_rot_angle; the beat is taken at
//     the clock edge where start is high and busy is low
//   - busy is held low: the pipeline takes a new beat on every cycle
//   - each result beat shows on o_out_x / o_out_y for one cycle with o_strobe
//     high; the receiver cannot hold results off and needs none
//   - path from the accepting edge to the strobe cycle: 1 quadrant stage,
//     16 cordic stages, 2 gain and rounding stages
//   - throughput: one beat per cycle, set by one registered add/subtract
//     stage per cordic iteration and a split multiply for the gain
//   - results come out in the order the beats went in, one per beat
//   - synchronous reset clears every valid bit, so beats in flight are
//     dropped and no strobe follows until new beats arrive
//   - angle: binary, 32768 means pi; rotation is counter-clockwise
//   - outputs are rounded to nearest, halves upward; a zero vector gives zero
module vector_rotate_by_angle
    import vrba_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [IN_W-1:0]  i_vec_x,
    input  logic signed [IN_W-1:0]  i_vec_y,
    input  logic signed [IN_W-1:0]  i_rot_angle,
    output logic                    o_strobe,
    output logic signed [OUT_W-1:0] o_out_x,
    output logic signed [OUT_W-1:0] o_out_y
);

    logic    accept;
    logic    quad_vld, cordic_vld;
    t_cordic quad_data, cordic_data;

    // never stalls: every cycle can take a beat
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // quarter-turn reduction, residual angle in [-pi/4, pi/4)
    vrba_quad u_quad (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_vec_x     (i_vec_x),
        .i_vec_y     (i_vec_y),
        .i_rot_angle (i_rot_angle),
        .o_valid     (quad_vld),
        .o_data      (quad_data)
    );

    // one registered stage per iteration
    vrba_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (quad_vld),
        .i_data  (quad_data),
        .o_valid (cordic_vld),
        .o_data  (cordic_data)
    );

    // gain compensation and rounding, two stages
    vrba_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cordic_vld),
        .i_x     (cordic_data.x),
        .i_y     (cordic_data.y),
        .o_valid (o_strobe),
        .o_x     (o_out_x),
        .o_y     (o_out_y)
    );

    // a strobe only ever follows an accepted beat by the pipeline latency
    a_strobe_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, LATENCY))
        else $error("result strobe without a matching accepted beat");

    // a zero vector comes out as zero whatever the angle
    a_zero_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_vec_x == '0 && i_vec_y == '0) |-> ##LATENCY
        (o_out_x == '0 && o_out_y == '0))
        else $error("zero vector did not give a zero result");

    // results stay within the largest possible magnitude
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_out_x <= 17'sd46341 && o_out_x >= -17'sd46341 &&
                      o_out_y <= 17'sd46341 && o_out_y >= -17'sd46341))
        else $error("result component out of range");

endmodule
